[hw/rtl/tgs_pkg.sv]
// Shared types, widths and constants of the trilateration grid search.
`default_nettype none

package tgs_pkg;

  // Fixed point of the measured ranges.
  localparam int RANGE_FRAC_BITS = 4;
  localparam int RNG_W           = 20;

  // Configuration register widths.
  localparam int ANCHOR_W = 15;
  localparam int STEP_W   = 10;
  localparam int HALF_W   = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR1_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR2_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR2_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HALF  = 3'd4;

  // Reset values of the configuration registers.
  localparam logic signed [ANCHOR_W-1:0] RST_ANCHOR1_X = 15'sd600;
  localparam logic signed [ANCHOR_W-1:0] RST_ANCHOR2_X = 15'sd300;
  localparam logic signed [ANCHOR_W-1:0] RST_ANCHOR2_Y = 15'sd600;
  localparam logic [STEP_W-1:0]          RST_GRID_STEP = 10'd10;
  localparam logic [HALF_W-1:0]          RST_GRID_HALF = 14'd5000;

  // Datapath widths.
  localparam int COORD_W = 16;                       // grid coordinate, signed
  localparam int DIFF_W  = COORD_W + 1;              // coordinate minus anchor
  localparam int OFF_W   = 16;                       // offset into the grid row
  localparam int SQ_W    = 32;                       // one squared difference
  localparam int E_W     = SQ_W + 1;                 // squared distance, mm^2
  localparam int SC_W    = E_W + 2 * RANGE_FRAC_BITS;
  localparam int Q_W     = 2 * RNG_W;                // squared range
  localparam int D_W     = (SC_W > Q_W) ? SC_W : Q_W;
  localparam int C_W     = D_W + 2;                  // sum of three residuals
  localparam int COST_W  = 44;
  localparam int CMP_W   = (C_W > COST_W) ? C_W : COST_W;

  // Division by three of a magnitude up to 2^15: (m * 43691) >> 17.
  localparam int DIV3_W     = 17;
  localparam int DIV3_SHIFT = 17;
  localparam logic [DIV3_W-1:0] DIV3_MUL = 17'd43691;
  localparam int PROD_W = COORD_W + DIV3_W;

  typedef struct packed {
    logic [RNG_W-1:0] range_to_anchor0;
    logic [RNG_W-1:0] range_to_anchor1;
    logic [RNG_W-1:0] range_to_anchor2;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] best_x;
    logic signed [COORD_W-1:0] best_y;
    logic [COST_W-1:0]         best_cost;
  } out_item_t;

  typedef struct packed {
    logic signed [ANCHOR_W-1:0] anchor1_x;
    logic signed [ANCHOR_W-1:0] anchor2_x;
    logic signed [ANCHOR_W-1:0] anchor2_y;
    logic [STEP_W-1:0]          grid_step;
    logic [HALF_W-1:0]          grid_half_span;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the input ranges
    logic load;      // square the ranges, start the centroid division
    logic init;      // set up the scan counters and clear the best point
    logic issue;     // send the current grid point into the cost pipeline
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_point;  // the current grid point is the last of the scan
    logic pipe_busy;   // a point is still in the cost pipeline
  } dp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/trilateration_grid_search.sv]
// Top level of the trilateration grid search: configuration registers, output register, core.
`default_nettype none

// Channel   Signals                              Beat
// in        in_valid / in_ready / in_data        three measured ranges
// out       out_valid / out_ready / out_data     best grid point and its cost
// cfg       cfg_valid / cfg_ready / cfg_index,   one register write
//           cfg_data
//
// One input beat runs a scan of an N by N grid, where N = floor(2*half_span/step) + 1.
// The cost pipeline evaluates one grid point per cycle, so the scan of the grid dominates;
// setup (load and init) comes before it, and draining the cost pipeline and handing off
// the result come after it.
// Reset is synchronous and restores the register defaults; no clearing pass is needed.
// A finished result waits in the output register, so the next input beat is taken
// while it is still unclaimed; only a second result waits for the register to free.

module trilateration_grid_search (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire tgs_pkg::in_item_t                      in_data,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output tgs_pkg::out_item_t                          out_data,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [tgs_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [tgs_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import tgs_pkg::*;

  cfg_t      cfg;
  dp_cmd_t   cmd;
  dp_stat_t  stat;
  out_item_t result;
  logic      publish;
  logic      out_free;

  // Configuration writes are always taken; an index past the last register is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.anchor1_x      <= RST_ANCHOR1_X;
      cfg.anchor2_x      <= RST_ANCHOR2_X;
      cfg.anchor2_y      <= RST_ANCHOR2_Y;
      cfg.grid_step      <= RST_GRID_STEP;
      cfg.grid_half_span <= RST_GRID_HALF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ANCHOR1_X: cfg.anchor1_x      <= $signed(cfg_data[ANCHOR_W-1:0]);
        CFG_ANCHOR2_X: cfg.anchor2_x      <= $signed(cfg_data[ANCHOR_W-1:0]);
        CFG_ANCHOR2_Y: cfg.anchor2_y      <= $signed(cfg_data[ANCHOR_W-1:0]);
        CFG_GRID_STEP: cfg.grid_step      <= cfg_data[STEP_W-1:0];
        CFG_GRID_HALF: cfg.grid_half_span <= cfg_data[HALF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The output register is free when empty or when its beat leaves this cycle.
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (publish) begin
      out_data <= result;
    end
  end

  tgs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .publish  (publish),
    .cmd      (cmd),
    .stat     (stat)
  );

  tgs_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .in_data (in_data),
    .cfg     (cfg),
    .result  (result)
  );

endmodule

`default_nettype wire

[hw/rtl/tgs_ctrl.sv]
// Sequencer of the trilateration grid search: setup, scan, drain and hand-off.
`default_nettype none

module tgs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             out_free,
  output logic                  publish,
  output tgs_pkg::dp_cmd_t      cmd,
  input  wire tgs_pkg::dp_stat_t stat
);
  import tgs_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_INIT  = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    publish     = 1'b0;
    cmd         = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_INIT;
      end
      ST_INIT: begin
        cmd.init   = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.last_point) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          publish    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/tgs_dp.sv]
// Datapath of the trilateration grid search: scan counters, cost pipeline, best point.
`default_nettype none

module tgs_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tgs_pkg::dp_cmd_t   cmd,
  output tgs_pkg::dp_stat_t       stat,
  input  wire tgs_pkg::in_item_t  in_data,
  input  wire tgs_pkg::cfg_t      cfg,
  output tgs_pkg::out_item_t      result
);
  import tgs_pkg::*;

  function automatic logic [D_W-1:0] abs_diff(input logic [D_W-1:0] a,
                                              input logic [D_W-1:0] b);
    logic [D_W-1:0] r;
    r = (a >= b) ? (a - b) : (b - a);
    return r;
  endfunction

  // Captured ranges and their squares.
  logic [RNG_W-1:0] r0, r1, r2;
  logic [Q_W-1:0]   q0, q1, q2;

  // Centroid division by three.
  logic signed [COORD_W-1:0] sum_x;
  logic signed [COORD_W-1:0] ext_y;
  logic [COORD_W-1:0]        mag_x, mag_y;
  logic [PROD_W-1:0]         prod_x, prod_y;
  logic                      neg_x, neg_y;
  logic [COORD_W-1:0]        quot_x, quot_y;
  logic signed [COORD_W-1:0] gx, gy;
  logic signed [DIFF_W-1:0]  start_x, start_y;

  // Scan counters.
  logic signed [COORD_W-1:0] x, y, y_base;
  logic [OFF_W-1:0]          x_off, y_off;
  logic [STEP_W-1:0]         step;
  logic [OFF_W-1:0]          span2;
  logic [OFF_W-1:0]          x_sum, y_sum;
  logic                      x_last, y_last;

  // Cost pipeline.
  logic [4:0]                v;
  logic signed [COORD_W-1:0] s1_x, s1_y, s2_x, s2_y, s3_x, s3_y, s4_x, s4_y, s5_x, s5_y;
  logic signed [DIFF_W-1:0]  s1_dx1, s1_dx2, s1_dy2;
  logic signed [DIFF_W-1:0]  ex_x, ex_y;
  logic signed [2*DIFF_W-1:0] m_xx0, m_xx1, m_xx2, m_yy, m_yy2;
  logic [SQ_W-1:0]           s2_xx0, s2_xx1, s2_xx2, s2_yy, s2_yy2;
  logic [E_W-1:0]            s3_e0, s3_e1, s3_e2;
  logic [SC_W-1:0]           sc0, sc1, sc2;
  logic [D_W-1:0]            s4_d0, s4_d1, s4_d2;
  logic [C_W-1:0]            s5_c;

  // Best point so far.
  logic                      have;
  logic [C_W-1:0]            best;
  logic signed [COORD_W-1:0] best_x, best_y;
  logic [COST_W-1:0]         cost_max;
  logic [CMP_W-1:0]          best_wide, max_wide;

  // Setup arithmetic.
  assign sum_x = COORD_W'($signed({cfg.anchor1_x[ANCHOR_W-1], cfg.anchor1_x})) +
                 COORD_W'($signed({cfg.anchor2_x[ANCHOR_W-1], cfg.anchor2_x}));
  assign ext_y = $signed({cfg.anchor2_y[ANCHOR_W-1], cfg.anchor2_y});
  assign mag_x = sum_x[COORD_W-1] ? COORD_W'(-sum_x) : COORD_W'(sum_x);
  assign mag_y = ext_y[COORD_W-1] ? COORD_W'(-ext_y) : COORD_W'(ext_y);

  assign quot_x  = prod_x[DIV3_SHIFT +: COORD_W];
  assign quot_y  = prod_y[DIV3_SHIFT +: COORD_W];
  assign gx      = neg_x ? -$signed(quot_x) : $signed(quot_x);
  assign gy      = neg_y ? -$signed(quot_y) : $signed(quot_y);
  assign start_x = $signed({gx[COORD_W-1], gx}) - $signed(DIFF_W'(cfg.grid_half_span));
  assign start_y = $signed({gy[COORD_W-1], gy}) - $signed(DIFF_W'(cfg.grid_half_span));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r0 <= in_data.range_to_anchor0;
      r1 <= in_data.range_to_anchor1;
      r2 <= in_data.range_to_anchor2;
    end
    if (cmd.load) begin
      q0     <= r0 * r0;
      q1     <= r1 * r1;
      q2     <= r2 * r2;
      prod_x <= PROD_W'(mag_x) * PROD_W'(DIV3_MUL);
      prod_y <= PROD_W'(mag_y) * PROD_W'(DIV3_MUL);
      neg_x  <= sum_x[COORD_W-1];
      neg_y  <= ext_y[COORD_W-1];
    end
  end

  // Scan order: X outer, Y inner; a row ends once the next offset passes twice the half span.
  assign step   = (cfg.grid_step == '0) ? STEP_W'(1) : cfg.grid_step;
  assign span2  = OFF_W'({cfg.grid_half_span, 1'b0});
  assign x_sum  = x_off + OFF_W'(step);
  assign y_sum  = y_off + OFF_W'(step);
  assign x_last = (x_sum > span2);
  assign y_last = (y_sum > span2);

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      x      <= start_x[COORD_W-1:0];
      y      <= start_y[COORD_W-1:0];
      y_base <= start_y[COORD_W-1:0];
      x_off  <= '0;
      y_off  <= '0;
    end else if (cmd.issue) begin
      if (y_last) begin
        y     <= y_base;
        y_off <= '0;
        if (!x_last) begin
          x     <= x + $signed(COORD_W'(step));
          x_off <= x_sum;
        end
      end else begin
        y     <= y + $signed(COORD_W'(step));
        y_off <= y_sum;
      end
    end
  end

  assign stat.last_point = x_last && y_last;
  assign stat.pipe_busy  = |v;

  // Cost pipeline, one grid point per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[3:0], cmd.issue};
    end
  end

  assign ex_x  = $signed({x[COORD_W-1], x});
  assign ex_y  = $signed({y[COORD_W-1], y});
  assign m_xx0 = $signed({s1_x[COORD_W-1], s1_x}) * $signed({s1_x[COORD_W-1], s1_x});
  assign m_yy  = $signed({s1_y[COORD_W-1], s1_y}) * $signed({s1_y[COORD_W-1], s1_y});
  assign m_xx1 = s1_dx1 * s1_dx1;
  assign m_xx2 = s1_dx2 * s1_dx2;
  assign m_yy2 = s1_dy2 * s1_dy2;

  assign sc0 = {s3_e0, (2 * RANGE_FRAC_BITS)'(0)};
  assign sc1 = {s3_e1, (2 * RANGE_FRAC_BITS)'(0)};
  assign sc2 = {s3_e2, (2 * RANGE_FRAC_BITS)'(0)};

  always_ff @(posedge clk) begin
    // Differences to the anchors.
    s1_x   <= x;
    s1_y   <= y;
    s1_dx1 <= ex_x - $signed(DIFF_W'(cfg.anchor1_x));
    s1_dx2 <= ex_x - $signed(DIFF_W'(cfg.anchor2_x));
    s1_dy2 <= ex_y - $signed(DIFF_W'(cfg.anchor2_y));
    // Squares.
    s2_x   <= s1_x;
    s2_y   <= s1_y;
    s2_xx0 <= m_xx0[SQ_W-1:0];
    s2_xx1 <= m_xx1[SQ_W-1:0];
    s2_xx2 <= m_xx2[SQ_W-1:0];
    s2_yy  <= m_yy[SQ_W-1:0];
    s2_yy2 <= m_yy2[SQ_W-1:0];
    // Squared distances.
    s3_x   <= s2_x;
    s3_y   <= s2_y;
    s3_e0  <= E_W'(s2_xx0) + E_W'(s2_yy);
    s3_e1  <= E_W'(s2_xx1) + E_W'(s2_yy);
    s3_e2  <= E_W'(s2_xx2) + E_W'(s2_yy2);
    // Residuals against the squared ranges.
    s4_x   <= s3_x;
    s4_y   <= s3_y;
    s4_d0  <= abs_diff(D_W'(sc0), D_W'(q0));
    s4_d1  <= abs_diff(D_W'(sc1), D_W'(q1));
    s4_d2  <= abs_diff(D_W'(sc2), D_W'(q2));
    // Cost.
    s5_x   <= s4_x;
    s5_y   <= s4_y;
    s5_c   <= C_W'(s4_d0) + C_W'(s4_d1) + C_W'(s4_d2);
  end

  // The first point of the scan always wins; after that only a strictly lower cost.
  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (cmd.init) begin
      have <= 1'b0;
    end else if (v[4]) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v[4] && (!have || (s5_c < best))) begin
      best   <= s5_c;
      best_x <= s5_x;
      best_y <= s5_y;
    end
  end

  assign cost_max  = '1;
  assign best_wide = CMP_W'(best);
  assign max_wide  = CMP_W'(cost_max);

  assign result.best_x    = best_x;
  assign result.best_y    = best_y;
  assign result.best_cost = (best_wide > max_wide) ? cost_max : COST_W'(best_wide);

endmodule

`default_nettype wire
